/* rtl/cat_pkg.sv */
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and constants for the call arc counter.
// ----------------------------------------------------------------------------
package cat_pkg;

  localparam int unsigned BucketsDef     = 4096;
  localparam int unsigned EntriesDef     = 4096;
  localparam int unsigned BucketBytesDef = 4;

  // text_size is 15 bits, so an in-range offset fits 15 bits
  localparam int unsigned OffW     = 15;
  // reciprocal shift for offset / BUCKET_BYTES, exact for 15-bit offsets and divisors up to 64
  localparam int unsigned DivShift = 22;

  typedef enum logic [2:0] {
    STAT_IGNORED  = 3'd0,
    STAT_RANGE    = 3'd1,
    STAT_HEAD     = 3'd2,
    STAT_MOVED    = 3'd3,
    STAT_NEW      = 3'd4,
    STAT_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_BASE   = 2'd1,
    REG_SIZE   = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_HEAD,
    S_HRDY,
    S_ENT,
    S_FIX,
    S_ALLOC
  } state_e;

  typedef struct packed {
    logic        enable;
    logic [31:0] text_base;
    logic [14:0] text_size;
    logic [12:0] arc_limit;
  } cfg_t;

endpackage

/* rtl/cat_ram.sv */
// ----------------------------------------------------------------------------
// cat_ram
// Generic single-port RAM, registered read, one access per cycle.
// ----------------------------------------------------------------------------
module cat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cat_ctrl.sv */
// ----------------------------------------------------------------------------
// cat_ctrl
// Sequencer: range check, bucket select, chain walk with read-modify-write
// of the head and entry memories, result register.
// ----------------------------------------------------------------------------
module cat_ctrl #(
  parameter int unsigned Buckets     = cat_pkg::BucketsDef,
  parameter int unsigned Entries     = cat_pkg::EntriesDef,
  parameter int unsigned BucketBytes = cat_pkg::BucketBytesDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  cat_pkg::cfg_t                           cfg_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [31:0]                             caller_i,
  input  logic [31:0]                             callee_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [2:0]                              status_o,
  output logic [11:0]                             arc_index_o,
  output logic [31:0]                             arc_count_o,
  output logic                                    clearing_o,
  // head memory
  output logic                                    head_en_o,
  output logic                                    head_we_o,
  output logic [$clog2(Buckets)-1:0]              head_addr_o,
  output logic [$clog2(Entries)-1:0]              head_wdata_o,
  input  logic [$clog2(Entries)-1:0]              head_rdata_i,
  // entry memory: {next, count, callee}
  output logic                                    ent_en_o,
  output logic                                    ent_we_o,
  output logic [$clog2(Entries)-1:0]              ent_addr_o,
  output logic [64+$clog2(Entries)-1:0]           ent_wdata_o,
  input  logic [64+$clog2(Entries)-1:0]           ent_rdata_i
);
  import cat_pkg::*;

  localparam int unsigned BW = $clog2(Buckets);
  localparam int unsigned IW = $clog2(Entries);
  localparam int unsigned EW = 64 + IW;
  localparam int unsigned SW = $clog2(Entries + 1);
  localparam int unsigned RecipW = DivShift + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((2 ** DivShift) + BucketBytes - 1) / BucketBytes);
  localparam logic [BW-1:0]   LastBucket = BW'(Buckets - 1);
  localparam logic [16:0]     BucketsW   = 17'(Buckets);
  localparam logic [16:0]     EntriesW   = 17'(Entries);
  localparam logic [SW-1:0]   EntriesS   = SW'(Entries);

  state_e state_q, state_d;

  logic [BW-1:0]   clr_q, clr_d;
  logic [31:0]     caller_q, caller_d;
  logic [31:0]     callee_q, callee_d;
  logic [OffW-1:0] off_q, off_d;
  logic [OffW-1:0] bucket_q, bucket_d;
  logic [IW-1:0]   head_q, head_d;
  logic [IW-1:0]   cur_q, cur_d;
  logic [IW-1:0]   prev_q, prev_d;
  logic [IW-1:0]   nxt_q, nxt_d;
  logic            first_q, first_d;
  logic [SW-1:0]   steps_q, steps_d;
  logic [EW-1:0]   prev_ent_q, prev_ent_d;
  logic [31:0]     cnt_q, cnt_d;
  logic [IW-1:0]   used_q, used_d;
  logic            stopped_q, stopped_d;

  logic            ovalid_q;
  logic [2:0]      ostat_q;
  logic [11:0]     oidx_q;
  logic [31:0]     ocnt_q;

  // datapath terms
  logic                      out_free;
  logic [31:0]               offset;
  logic                      skip, out_range;
  logic [OffW+RecipW-1:0]    prod;
  logic                      bucket_ok;
  logic [BW+OffW-1:0]        bucket_w;
  logic                      hd_ok;
  logic [IW-1:0]             hd;
  logic [31:0]               rd_callee, rd_cnt, inc;
  logic [IW-1:0]             rd_next;
  logic                      hit;
  logic [SW-1:0]             steps_n;
  logic                      walk_on;
  logic [IW:0]               cand;
  logic                      ovf;

  // result handed to the output register
  logic            commit;
  status_e         res_stat;
  logic [IW-1:0]   res_idx;
  logic [31:0]     res_cnt;
  logic [IW+11:0]  res_idx_w;

  assign out_free  = !ovalid_q || out_ready_i;
  assign offset    = caller_q - cfg_i.text_base;
  assign skip      = !cfg_i.enable || stopped_q;
  assign out_range = offset >= {17'd0, cfg_i.text_size};
  assign prod      = off_q * Recip;
  assign bucket_ok = {2'b00, bucket_q} < BucketsW;
  assign bucket_w  = {{BW{1'b0}}, bucket_q};
  assign hd_ok     = 17'(head_rdata_i) < EntriesW;
  assign hd        = hd_ok ? head_rdata_i : '0;
  assign rd_callee = ent_rdata_i[31:0];
  assign rd_cnt    = ent_rdata_i[63:32];
  assign rd_next   = ent_rdata_i[EW-1:64];
  assign hit       = rd_callee == callee_q;
  assign inc       = (&rd_cnt) ? rd_cnt : rd_cnt + 32'd1;
  assign steps_n   = first_q ? '0 : steps_q + SW'(1);
  assign walk_on   = (rd_next != '0) && (17'(rd_next) < EntriesW) && (steps_n < EntriesS);
  assign cand      = (IW+1)'(used_q) + (IW+1)'(1);
  assign ovf       = (17'(cand) >= 17'(cfg_i.arc_limit)) || (17'(cand) >= EntriesW);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == LastBucket) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        if (skip || out_range) begin
          if (out_free) state_d = S_IDLE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:   state_d = S_HEAD;
      S_HEAD: begin
        if (!bucket_ok) begin
          if (out_free) state_d = S_IDLE;
        end else begin
          state_d = S_HRDY;
        end
      end
      S_HRDY:  state_d = (hd == '0) ? S_ALLOC : S_ENT;
      S_ENT: begin
        if (hit) begin
          if (!first_q) state_d = S_FIX;
          else if (out_free) state_d = S_IDLE;
        end else if (!walk_on) begin
          state_d = S_ALLOC;
        end
      end
      S_FIX:   if (out_free) state_d = S_IDLE;
      S_ALLOC: if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // memory controls, datapath updates, results
  always_comb begin
    clr_d      = clr_q;
    caller_d   = caller_q;
    callee_d   = callee_q;
    off_d      = off_q;
    bucket_d   = bucket_q;
    head_d     = head_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    nxt_d      = nxt_q;
    first_d    = first_q;
    steps_d    = steps_q;
    prev_ent_d = prev_ent_q;
    cnt_d      = cnt_q;
    used_d     = used_q;
    stopped_d  = stopped_q;
    head_en_o    = 1'b0;
    head_we_o    = 1'b0;
    head_addr_o  = bucket_w[BW-1:0];
    head_wdata_o = cur_q;
    ent_en_o     = 1'b0;
    ent_we_o     = 1'b0;
    ent_addr_o   = cur_q;
    ent_wdata_o  = {rd_next, inc, rd_callee};
    in_ready_o   = 1'b0;
    commit       = 1'b0;
    res_stat     = STAT_IGNORED;
    res_idx      = '0;
    res_cnt      = '0;
    case (state_q)
      S_CLEAR: begin
        head_en_o    = 1'b1;
        head_we_o    = 1'b1;
        head_addr_o  = clr_q;
        head_wdata_o = '0;
        clr_d        = clr_q + BW'(1);
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        caller_d   = caller_i;
        callee_d   = callee_i;
      end
      S_CHECK: begin
        off_d = offset[OffW-1:0];
        if (skip) begin
          commit = out_free;
        end else if (out_range) begin
          commit   = out_free;
          res_stat = STAT_RANGE;
        end
      end
      S_DIV: bucket_d = prod[DivShift +: OffW];
      S_HEAD: begin
        if (!bucket_ok) begin
          commit   = out_free;
          res_stat = STAT_RANGE;
        end else begin
          head_en_o = 1'b1;
        end
      end
      S_HRDY: begin
        head_d     = hd;
        cur_d      = hd;
        first_d    = 1'b1;
        steps_d    = '0;
        ent_en_o   = hd != '0;
        ent_addr_o = hd;
      end
      S_ENT: begin
        if (hit) begin
          if (first_q) begin
            ent_en_o = out_free;
            ent_we_o = out_free;
            commit   = out_free;
            res_stat = STAT_HEAD;
            res_idx  = cur_q;
            res_cnt  = inc;
          end else begin
            // counted entry goes to the front; unlink it from prev in S_FIX
            ent_en_o    = 1'b1;
            ent_we_o    = 1'b1;
            ent_wdata_o = {head_q, inc, rd_callee};
            nxt_d       = rd_next;
            cnt_d       = inc;
          end
        end else begin
          prev_ent_d = ent_rdata_i;
          prev_d     = cur_q;
          steps_d    = steps_n;
          first_d    = 1'b0;
          if (walk_on) begin
            ent_en_o   = 1'b1;
            ent_addr_o = rd_next;
            cur_d      = rd_next;
          end
        end
      end
      S_FIX: begin
        ent_en_o     = out_free;
        ent_we_o     = out_free;
        ent_addr_o   = prev_q;
        ent_wdata_o  = {nxt_q, prev_ent_q[63:0]};
        head_en_o    = out_free;
        head_we_o    = out_free;
        commit       = out_free;
        res_stat     = STAT_MOVED;
        res_idx      = cur_q;
        res_cnt      = cnt_q;
      end
      S_ALLOC: begin
        commit = out_free;
        if (ovf) begin
          res_stat  = STAT_OVERFLOW;
          stopped_d = stopped_q | out_free;
        end else begin
          ent_en_o     = out_free;
          ent_we_o     = out_free;
          ent_addr_o   = cand[IW-1:0];
          ent_wdata_o  = {head_q, 32'd1, callee_q};
          head_en_o    = out_free;
          head_we_o    = out_free;
          head_wdata_o = cand[IW-1:0];
          res_stat     = STAT_NEW;
          res_idx      = cand[IW-1:0];
          res_cnt      = 32'd1;
          if (out_free) used_d = cand[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign res_idx_w = {12'd0, res_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      used_q    <= '0;
      stopped_q <= 1'b0;
      ovalid_q  <= 1'b0;
      first_q   <= 1'b0;
      steps_q   <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      used_q    <= used_d;
      stopped_q <= stopped_d;
      first_q   <= first_d;
      steps_q   <= steps_d;
      if (commit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    caller_q   <= caller_d;
    callee_q   <= callee_d;
    off_q      <= off_d;
    bucket_q   <= bucket_d;
    head_q     <= head_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    nxt_q      <= nxt_d;
    prev_ent_q <= prev_ent_d;
    cnt_q      <= cnt_d;
    if (commit) begin
      ostat_q <= res_stat;
      oidx_q  <= res_idx_w[11:0];
      ocnt_q  <= res_cnt;
    end
  end

  assign out_valid_o = ovalid_q;
  assign status_o    = ostat_q;
  assign arc_index_o = oidx_q;
  assign arc_count_o = ocnt_q;
  assign clearing_o  = state_q == S_CLEAR;

endmodule

/* rtl/call_arc_counter_top.sv */
// ----------------------------------------------------------------------------
// call_arc_counter_top
// Call-graph arc table: counts caller/callee pairs in per-bucket chains
// with move-to-front, entries allocated from a bump counter.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata: caller_pc, callee_pc
//  m_axis    out        m_axis_tvalid/tready      tdata: status, arc_index, arc_count
//  cfg       in         cfg_we_i (no wait)        cfg_idx_i selects register
//
//  One transaction at a time; s_axis_tready is high only while idle.
//  The result of an ignored call or an offset past text_size is registered
//  from the check step, of a bucket past the last one from the head step,
//  and of a head hit or a new arc in an empty bucket after check, divide,
//  head read and entry read or allocation. Each chain link past the head
//  adds one entry-memory read; a moved hit adds one more step for the
//  second write-back, a new arc after a walk one for the allocation. The
//  block is back in idle as the result is registered and takes the next call.
//  After reset a clearing pass writes every bucket head to zero, with
//  s_axis_tready low; configuration writes are taken meanwhile.
//  A waiting result stalls only the final, committing step of the next
//  transaction; the result register frees the input side otherwise.
//
module call_arc_counter_top #(
  parameter int unsigned BUCKETS      = cat_pkg::BucketsDef,
  parameter int unsigned ENTRIES      = cat_pkg::EntriesDef,
  parameter int unsigned BUCKET_BYTES = cat_pkg::BucketBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] caller_pc, [63:32] callee_pc
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [2:0] status, [14:3] arc_index,
                                        // [46:15] arc_count, [47] zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import cat_pkg::*;

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned EW = 64 + IW;

  cfg_t cfg_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b0;
      cfg_q.text_base <= 32'd0;
      cfg_q.text_size <= 15'd16384;
      cfg_q.arc_limit <= 13'd4096;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_ENABLE: cfg_q.enable    <= cfg_wdata_i[0];
        REG_BASE:   cfg_q.text_base <= cfg_wdata_i;
        REG_SIZE:   cfg_q.text_size <= cfg_wdata_i[14:0];
        REG_LIMIT:  cfg_q.arc_limit <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  logic          head_en, head_we;
  logic [BW-1:0] head_addr;
  logic [IW-1:0] head_wdata, head_rdata;
  logic          ent_en, ent_we;
  logic [IW-1:0] ent_addr;
  logic [EW-1:0] ent_wdata, ent_rdata;
  logic [2:0]    status;
  logic [11:0]   arc_index;
  logic [31:0]   arc_count;
  logic          clearing;

  cat_ctrl #(
    .Buckets     (BUCKETS),
    .Entries     (ENTRIES),
    .BucketBytes (BUCKET_BYTES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .caller_i     (s_axis_tdata_i[31:0]),
    .callee_i     (s_axis_tdata_i[63:32]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (status),
    .arc_index_o  (arc_index),
    .arc_count_o  (arc_count),
    .clearing_o   (clearing),
    .head_en_o    (head_en),
    .head_we_o    (head_we),
    .head_addr_o  (head_addr),
    .head_wdata_o (head_wdata),
    .head_rdata_i (head_rdata),
    .ent_en_o     (ent_en),
    .ent_we_o     (ent_we),
    .ent_addr_o   (ent_addr),
    .ent_wdata_o  (ent_wdata),
    .ent_rdata_i  (ent_rdata)
  );

  // bucket heads: index of first entry, 0 = empty chain
  cat_ram #(
    .Width (IW),
    .Depth (BUCKETS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .en_i    (head_en),
    .we_i    (head_we),
    .addr_i  (head_addr),
    .wdata_i (head_wdata),
    .rdata_o (head_rdata)
  );

  // arc entries: {next, count, callee}; entry 0 never written
  cat_ram #(
    .Width (EW),
    .Depth (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .en_i    (ent_en),
    .we_i    (ent_we),
    .addr_i  (ent_addr),
    .wdata_i (ent_wdata),
    .rdata_o (ent_rdata)
  );

  assign m_axis_tdata_o = {1'b0, arc_count, arc_index, status};

  // no input taken while the head memory is being cleared
  a_clear_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready_o)
    else $error("input accepted during clearing pass");

  // entries are never written during the clearing pass
  a_clear_no_entry_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !(ent_en && ent_we))
    else $error("entry write during clearing pass");

  // results that touch no entry carry zero index and count
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (status == STAT_IGNORED || status == STAT_RANGE ||
                         status == STAT_OVERFLOW))
    |-> (arc_index == 12'd0 && arc_count == 32'd0))
    else $error("empty result with nonzero index or count");

  // a fresh arc always starts at count one
  a_new_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && status == STAT_NEW) |-> arc_count == 32'd1)
    else $error("new arc with count other than one");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for call_arc_counter_top. Call events go in on the
// s_axis side; a shadow arc table in the bench predicts each status, arc
// index and count, and every result on m_axis is checked against the
// oldest prediction. A short directed table comes first, then random
// phases under several register settings, then a pool overflow and calls after it.
// ----------------------------------------------------------------------------
module testbench;
  import cat_pkg::*;

  localparam int N_BUCKETS        = BucketsDef;
  localparam int N_ENTRIES        = EntriesDef;
  localparam int BYTES_PER_BUCKET = BucketBytesDef;
  localparam int HOT_SLOTS        = 12;
  localparam int POOL_SIZE        = 10;

  typedef struct packed {
    status_e     status;
    logic [11:0] index;
    logic [31:0] count;
  } arc_result_t;

  typedef enum logic { ROW_CALL, ROW_CFG } row_kind_e;

  // ROW_CALL: a = caller, b = callee. ROW_CFG: a = register index, b = data.
  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    arc_result_t res;
  } dir_row_t;

  // DUT-facing signals; the inputs are known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i  = '0;    // [31:0] caller_pc, [63:32] callee_pc
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;          // [2:0] status, [14:3] arc_index,
                                        // [46:15] arc_count, [47] zero
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_idx_i       = '0;
  logic [31:0] cfg_wdata_i     = '0;

  // shadow registers (reset values of the block)
  logic        cfg_enable = 1'b0;
  logic [31:0] cfg_base   = 32'd0;
  logic [14:0] cfg_size   = 15'd16384;
  logic [12:0] cfg_limit  = 13'd4096;

  // shadow arc table
  logic [11:0] chain_head [N_BUCKETS];
  logic [31:0] arc_callee [N_ENTRIES];
  logic [31:0] arc_count  [N_ENTRIES];
  logic [11:0] arc_next   [N_ENTRIES];
  int          arcs_used = 0;
  logic        halted    = 1'b0;

  arc_result_t pending_arcs [$];   // predicted results, oldest first
  dir_row_t    dir_rows [$];
  int          error_count = 0;
  logic        steady_flow = 1'b0; // both sides stop idling while set

  // per-phase hot spots: a few bucket offsets and a few callees so chains build up
  logic [31:0] hot_off     [HOT_SLOTS];
  logic [31:0] callee_pool [POOL_SIZE];

  call_arc_counter_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow arc table
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] bump_count(input logic [11:0] idx);
    if (arc_count[idx] != 32'hFFFF_FFFF) arc_count[idx] = arc_count[idx] + 32'd1;
    return arc_count[idx];
  endfunction

  function automatic arc_result_t predict_call(input logic [31:0] caller,
                                               input logic [31:0] callee);
    arc_result_t r;
    logic [31:0] offset;
    logic [31:0] bucket;
    logic [11:0] head;
    logic [11:0] prev;
    logic [11:0] cur;
    int          steps;
    r.status = STAT_IGNORED;
    r.index  = 12'd0;
    r.count  = 32'd0;
    if (!cfg_enable || halted) return r;
    // offset wraps mod 2^32; >= size is out of range
    offset   = caller - cfg_base;
    r.status = STAT_RANGE;
    if (offset >= {17'd0, cfg_size}) return r;
    bucket = offset / BYTES_PER_BUCKET;
    if (bucket >= N_BUCKETS) return r;
    head = chain_head[bucket];
    if (head != 12'd0) begin
      if (arc_callee[head] == callee) begin
        r.status = STAT_HEAD;
        r.index  = head;
        r.count  = bump_count(head);
        return r;
      end
      prev  = head;
      cur   = arc_next[head];
      steps = 0;
      while (cur != 12'd0 && steps < N_ENTRIES) begin
        if (arc_callee[cur] == callee) begin
          // hit down the chain: unlink and move to the front
          r.count            = bump_count(cur);
          arc_next[prev]     = arc_next[cur];
          arc_next[cur]      = head;
          chain_head[bucket] = cur;
          r.status           = STAT_MOVED;
          r.index            = cur;
          return r;
        end
        prev  = cur;
        cur   = arc_next[cur];
        steps = steps + 1;
      end
    end
    // miss: take the next slot, or overflow and stop for good
    if (arcs_used + 1 >= int'(cfg_limit) || arcs_used + 1 >= N_ENTRIES) begin
      halted   = 1'b1;
      r.status = STAT_OVERFLOW;
      return r;
    end
    arcs_used             = arcs_used + 1;
    arc_callee[arcs_used] = callee;
    arc_count[arcs_used]  = 32'd1;
    arc_next[arcs_used]   = head;
    chain_head[bucket]    = arcs_used[11:0];
    r.status              = STAT_NEW;
    r.index               = arcs_used[11:0];
    r.count               = 32'd1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic dir_row_t call_row(input logic [31:0] c, input logic [31:0] e);
    dir_row_t row;
    row.kind  = ROW_CALL;
    row.a     = c;
    row.b     = e;
    row.typed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  function automatic dir_row_t hit_row(input logic [31:0] c, input logic [31:0] e,
                                       input status_e st, input logic [11:0] i,
                                       input logic [31:0] n);
    dir_row_t row;
    row            = call_row(c, e);
    row.typed      = 1'b1;
    row.res.status = st;
    row.res.index  = i;
    row.res.count  = n;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input reg_e r, input logic [31:0] v);
    dir_row_t row;
    row      = call_row({30'd0, r}, v);
    row.kind = ROW_CFG;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Presents one call event, waits for the transaction and records what
  // the block owes for it. A typed expectation overrides the prediction,
  // but the shadow table is still updated.
  task automatic send_call(input logic [31:0] caller, input logic [31:0] callee,
                           input logic typed, input arc_result_t given);
    arc_result_t want;
    while (!steady_flow && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {callee, caller};
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = predict_call(caller, callee);
    pending_arcs.push_back(typed ? given : want);
  endtask

  // Holds off the sender until every result is in and the block is idle.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_arcs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called with the block idle. Mirrors the write into the shadow regs.
  task automatic write_reg(input reg_e r, input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    case (r)
      REG_ENABLE: cfg_enable = v[0];
      REG_BASE:   cfg_base   = v;
      REG_SIZE:   cfg_size   = v[14:0];
      REG_LIMIT:  cfg_limit  = v[12:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Picks hot bucket offsets inside the covered text and a small callee pool.
  task automatic prepare_phase();
    int span;
    span = (cfg_size > 15'd16384) ? 16384 : int'(cfg_size);
    if (span == 0) span = 1;
    foreach (hot_off[i]) hot_off[i] = $urandom_range(0, span - 1) & ~32'h3;
    foreach (callee_pool[i]) callee_pool[i] = $urandom;
  endtask

  // Mostly well-formed calls into hot buckets; some noise and boundary misses.
  task automatic random_call();
    int          roll;
    logic [31:0] off;
    logic [31:0] caller;
    logic [31:0] callee;
    roll = $urandom_range(0, 99);
    if (roll == 0) drain_results();   // occasional full drain mid-phase
    if (roll < 85) begin
      off    = hot_off[$urandom_range(0, HOT_SLOTS - 1)] + $urandom_range(0, 3);
      caller = cfg_base + off;
      callee = callee_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (roll < 95) begin
      caller = $urandom;
      callee = $urandom;
    end else begin
      // just past the size, or past the last bucket when size exceeds it
      if (cfg_size > 15'd16384 && roll[0])
        off = 16384 + $urandom_range(0, int'(cfg_size) - 16385);
      else
        off = {17'd0, cfg_size} + $urandom_range(0, 3);
      caller = cfg_base + off;
      callee = callee_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    send_call(caller, callee, 1'b0, '0);
  endtask

  task automatic random_calls(input int n);
    repeat (n) random_call();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: checks each result transaction, stalls at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    arc_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_arcs.size() == 0) begin
        $error("result with no call waiting: status %0d index %0d count %0d",
               m_axis_tdata_o[2:0], m_axis_tdata_o[14:3], m_axis_tdata_o[46:15]);
        error_count++;
      end else begin
        want = pending_arcs.pop_front();
        if (m_axis_tdata_o[2:0] != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata_o[2:0]);
          error_count++;
        end
        if (m_axis_tdata_o[14:3] != want.index) begin
          $error("arc_index: expected %0d, got %0d", want.index, m_axis_tdata_o[14:3]);
          error_count++;
        end
        if (m_axis_tdata_o[46:15] != want.count) begin
          $error("arc_count: expected %0d, got %0d", want.count, m_axis_tdata_o[46:15]);
          error_count++;
        end
      end
    end
    m_axis_tready_i <= steady_flow || ($urandom_range(0, 99) >= 8);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    for (k = 0; k < N_BUCKETS; k++) chain_head[k] = 12'd0;
    for (k = 0; k < N_ENTRIES; k++) begin
      arc_callee[k] = 32'd0;
      arc_count[k]  = 32'd0;
      arc_next[k]   = 12'd0;
    end

    // Directed table. Registers start at reset values: disabled, base 0,
    // size 16384, limit 4096.
    dir_rows.push_back(hit_row(32'h0, 32'h0, STAT_IGNORED, 0, 0));        // disabled
    dir_rows.push_back(hit_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, STAT_IGNORED, 0, 0));
    dir_rows.push_back(cfg_row(REG_ENABLE, 32'd1));
    dir_rows.push_back(hit_row(32'h4000, 32'h1, STAT_RANGE, 0, 0));       // offset == size
    dir_rows.push_back(hit_row(32'h3FFF, 32'hFFFF_FFFF, STAT_NEW, 1, 1)); // last bucket
    dir_rows.push_back(hit_row(32'h3FFC, 32'hFFFF_FFFF, STAT_HEAD, 1, 2));
    dir_rows.push_back(hit_row(32'h3FFD, 32'h0, STAT_NEW, 2, 1));
    dir_rows.push_back(hit_row(32'h3FFE, 32'hFFFF_FFFF, STAT_MOVED, 1, 3));
    dir_rows.push_back(hit_row(32'h0, 32'h1234_5678, STAT_NEW, 3, 1));
    dir_rows.push_back(hit_row(32'h3, 32'h0, STAT_NEW, 4, 1));
    dir_rows.push_back(hit_row(32'h1, 32'hA5A5_A5A5, STAT_NEW, 5, 1));
    dir_rows.push_back(hit_row(32'h2, 32'h1234_5678, STAT_MOVED, 3, 2));  // two links down
    dir_rows.push_back(hit_row(32'h2, 32'h1234_5678, STAT_HEAD, 3, 3));
    dir_rows.push_back(cfg_row(REG_BASE, 32'hFFFF_FFF0));                 // text wraps past 0
    dir_rows.push_back(call_row(32'h0000_0004, 32'hDEAD_BEEF));
    dir_rows.push_back(hit_row(32'hFFFF_FFEF, 32'h1, STAT_RANGE, 0, 0));  // offset all ones
    dir_rows.push_back(cfg_row(REG_SIZE, 32'd0));                         // empty text
    dir_rows.push_back(hit_row(32'hFFFF_FFF0, 32'h5A5A_5A5A, STAT_RANGE, 0, 0));
    dir_rows.push_back(cfg_row(REG_SIZE, 32'h7FFF));                      // beyond the buckets
    dir_rows.push_back(hit_row(32'h0000_3FF0, 32'h0, STAT_RANGE, 0, 0));  // bucket 4096
    dir_rows.push_back(hit_row(32'h0000_7FEE, 32'h0, STAT_RANGE, 0, 0));
    dir_rows.push_back(hit_row(32'h0000_7FEF, 32'h0, STAT_RANGE, 0, 0));  // offset == size
    dir_rows.push_back(call_row(32'h0000_3FEF, 32'h0));
    dir_rows.push_back(cfg_row(REG_BASE, 32'd0));
    dir_rows.push_back(cfg_row(REG_SIZE, 32'd16384));
    dir_rows.push_back(cfg_row(REG_ENABLE, 32'd0));
    dir_rows.push_back(hit_row(32'h2, 32'h1234_5678, STAT_IGNORED, 0, 0));
    dir_rows.push_back(cfg_row(REG_ENABLE, 32'd1));
    dir_rows.push_back(call_row(32'h2, 32'h1234_5678));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(reg_e'(dir_rows[i].a[1:0]), dir_rows[i].b);
      end else begin
        send_call(dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random phases, each under its own register setting. Limits stay well
    // above the pool fill so nothing overflows before the last phase.
    for (k = 0; k < 7; k++) begin
      drain_results();
      case (k)
        0: begin
          write_reg(REG_BASE, 32'd0);
          write_reg(REG_SIZE, 32'd16384);
          write_reg(REG_LIMIT, 32'd4096);
        end
        1: begin
          write_reg(REG_BASE, $urandom & ~32'h3);
          write_reg(REG_SIZE, $urandom_range(64, 16384));
          write_reg(REG_LIMIT, 32'd8191);
        end
        2: begin
          write_reg(REG_BASE, 32'hFFFF_FFFF);
          write_reg(REG_SIZE, 32'h7FFF);
          write_reg(REG_LIMIT, 32'd4096);
        end
        3: begin
          // small text: few buckets, long chains
          write_reg(REG_BASE, $urandom);
          write_reg(REG_SIZE, $urandom_range(4, 256));
          write_reg(REG_LIMIT, arcs_used + 300 + $urandom_range(0, 200));
        end
        4: begin
          write_reg(REG_BASE, $urandom);
          write_reg(REG_SIZE, 32'd16384);
          write_reg(REG_LIMIT, 32'd4096);
        end
        5: begin
          write_reg(REG_BASE, $urandom);
          write_reg(REG_SIZE, $urandom_range(1, 32767));
          write_reg(REG_LIMIT, 32'd4096);
        end
        default: begin
          // one byte of text: a single bucket, every callee in one chain
          write_reg(REG_BASE, $urandom);
          write_reg(REG_SIZE, 32'd1);
          write_reg(REG_LIMIT, 32'd4096);
        end
      endcase
      prepare_phase();
      steady_flow <= (k == 2);   // long stretch without idling on either side
      random_calls(230);
    end
    steady_flow <= 1'b0;

    // Pool overflow: a limit just above the fill, then run until it trips.
    drain_results();
    write_reg(REG_BASE, 32'd0);
    write_reg(REG_SIZE, 32'd64);
    write_reg(REG_LIMIT, arcs_used + 6);
    prepare_phase();
    k = 0;
    while (!halted && k < 400) begin
      random_call();
      k++;
    end
    random_calls(12);

    // Stopped stays set across enable writes; limit extremes change nothing.
    drain_results();
    write_reg(REG_ENABLE, 32'd0);
    random_calls(2);
    drain_results();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_LIMIT, 32'd0);
    write_reg(REG_LIMIT, 32'd1);
    random_calls(3);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, clearing pass included.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/cat_pkg.sv
rtl/cat_ram.sv
rtl/cat_ctrl.sv
rtl/call_arc_counter_top.sv
dv/testbench.sv
